/* rtl/psl_pkg.sv */
// Shared types, codes and command/status bundles for the positional sequential list.
package psl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OUT_POS_W    = 5;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_GET    = 3'd2;
    localparam logic [2:0] REQ_LOCATE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic signed [31:0]   read_value;
        logic [OUT_POS_W-1:0] found_position;
        logic [OUT_POS_W-1:0] list_length;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_CHK,
        ST_INS_WR,
        ST_INS_PUT,
        ST_CAPTURE,
        ST_DEL_CHK,
        ST_DEL_WR,
        ST_LOC_CHK,
        ST_LOC_CMP,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX_M1,
        RD_POS_M1,
        RD_IDX
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_UP,
        WR_DOWN,
        WR_POS
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_FAIL,
        RES_OK,
        RES_READ,
        RES_FOUND
    } t_res_op;

    typedef struct packed {
        logic    latch_req;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_res_op res_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       ins_ok;
        logic       pos_ok;
        logic       idx_ge_pos;
        logic       idx_lt_cnt;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage

/* rtl/psl_ctrl.sv */
// Controller state machine that sequences list requests over the datapath.
module psl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psl_pkg::t_sts i_sts,
    output psl_pkg::t_cmd o_cmd
);
    import psl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx_op   = IDX_HOLD;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.res_op   = RES_HOLD;
        o_cmd.rd_sel   = RD_IDX;
        o_cmd.wr_sel   = WR_UP;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.req_type)
                    REQ_INSERT: begin
                        if (i_sts.ins_ok) begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = ST_INS_CHK;
                        end else begin
                            o_cmd.res_op = RES_FAIL;
                            n_state      = ST_DONE;
                        end
                    end
                    REQ_DELETE, REQ_GET: begin
                        if (i_sts.pos_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS_M1;
                            n_state      = ST_CAPTURE;
                        end else begin
                            o_cmd.res_op = RES_FAIL;
                            n_state      = ST_DONE;
                        end
                    end
                    REQ_LOCATE: begin
                        o_cmd.idx_op = IDX_ZERO;
                        n_state      = ST_LOC_CHK;
                    end
                    REQ_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLR;
                        o_cmd.res_op = RES_OK;
                        n_state      = ST_DONE;
                    end
                    default: begin
                        o_cmd.res_op = RES_FAIL;
                        n_state      = ST_DONE;
                    end
                endcase
            end
            ST_INS_CHK: begin
                if (i_sts.idx_ge_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = ST_INS_WR;
                end else begin
                    n_state = ST_INS_PUT;
                end
            end
            ST_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_UP;
                o_cmd.idx_op = IDX_DEC;
                n_state      = ST_INS_CHK;
            end
            ST_INS_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_POS;
                o_cmd.cnt_op = CNT_INC;
                o_cmd.res_op = RES_OK;
                n_state      = ST_DONE;
            end
            ST_CAPTURE: begin
                o_cmd.res_op = RES_READ;
                if (i_sts.req_type == REQ_GET) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.idx_op = IDX_POS;
                    n_state      = ST_DEL_CHK;
                end
            end
            ST_DEL_CHK: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = ST_DEL_WR;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = ST_DONE;
                end
            end
            ST_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_DOWN;
                o_cmd.idx_op = IDX_INC;
                n_state      = ST_DEL_CHK;
            end
            ST_LOC_CHK: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = ST_LOC_CMP;
                end else begin
                    o_cmd.res_op = RES_FAIL;
                    n_state      = ST_DONE;
                end
            end
            ST_LOC_CMP: begin
                if (i_sts.match) begin
                    o_cmd.res_op = RES_FOUND;
                    n_state      = ST_DONE;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = ST_LOC_CHK;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/psl_dp.sv */
// Datapath: element memory, count, walk index, result and output registers.
module psl_dp #(
    parameter int CAPACITY = psl_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psl_pkg::t_req i_in_data,
    input  psl_pkg::t_cmd i_cmd,
    output psl_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output psl_pkg::t_rsp o_out_data
);
    import psl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0]          r_mem [CAPACITY];
    t_req                 r_req;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_count;
    logic [31:0]          r_rdata;
    logic                 r_ok;
    logic [31:0]          r_rv;
    logic [OUT_POS_W-1:0] r_fp;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic [CW-1:0] n_idx;
    logic [CW-1:0] n_count;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] fp_x;
    logic [XW-1:0] rd_ix;
    logic [XW-1:0] wr_ix;
    logic [31:0]   wr_data;

    assign pos_x = XW'(r_req.position);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);
    assign fp_x  = idx_x + XW'(1);

    assign o_sts.req_type   = r_req.req_type;
    assign o_sts.ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + XW'(1))
                              && (r_count < CW'(CAPACITY));
    assign o_sts.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
    assign o_sts.idx_ge_pos = (idx_x >= pos_x);
    assign o_sts.idx_lt_cnt = (r_idx < r_count);
    assign o_sts.match      = (r_rdata == r_req.value);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: rd_ix = idx_x - XW'(1);
            RD_POS_M1: rd_ix = pos_x - XW'(1);
            RD_IDX:    rd_ix = idx_x;
            default:   rd_ix = idx_x;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_UP: begin
                wr_ix   = idx_x;
                wr_data = r_rdata;
            end
            WR_DOWN: begin
                wr_ix   = idx_x - XW'(1);
                wr_data = r_rdata;
            end
            WR_POS: begin
                wr_ix   = pos_x - XW'(1);
                wr_data = r_req.value;
            end
            default: begin
                wr_ix   = idx_x;
                wr_data = r_rdata;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = pos_x[CW-1:0];
            IDX_ZERO:  n_idx = '0;
            IDX_DEC:   n_idx = r_idx - CW'(1);
            IDX_INC:   n_idx = r_idx + CW'(1);
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_ix[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_ix[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req <= i_in_data;
        end
        r_idx <= n_idx;
        case (i_cmd.res_op)
            RES_FAIL: begin
                r_ok <= 1'b0;
                r_rv <= '0;
                r_fp <= '0;
            end
            RES_OK: begin
                r_ok <= 1'b1;
                r_rv <= '0;
                r_fp <= '0;
            end
            RES_READ: begin
                r_ok <= 1'b1;
                r_rv <= r_rdata;
                r_fp <= '0;
            end
            RES_FOUND: begin
                r_ok <= 1'b1;
                r_rv <= '0;
                r_fp <= fp_x[OUT_POS_W-1:0];
            end
            default: begin
                r_ok <= r_ok;
            end
        endcase
        if (i_cmd.load_out) begin
            r_out.ok             <= r_ok;
            r_out.read_value     <= r_rv;
            r_out.found_position <= r_fp;
            r_out.list_length    <= cnt_x[OUT_POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (wr_ix < XW'(CAPACITY)))
        else $error("write outside the store");

    a_read_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (rd_ix < cnt_x))
        else $error("read of an entry beyond the list");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

/* rtl/positional_sequential_list_core.sv */
// Clear and rejected requests go straight to the result; get reads one entry. Insert shifts entries
// up from the tail to the position, delete shifts later entries down, and locate compares entries
// from the head. Each shifted entry is read, then written; each searched entry is read, then compared.
// One request is in work at a time: input is ready in the cycle after the result loads into the
// output register, which loads only once the previous result has transferred.
// Reset empties the list (count to zero) and drops any pending result; no clearing pass.
module positional_sequential_list_core #(
    parameter int CAPACITY = psl_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psl_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output psl_pkg::t_rsp o_out_data
);
    import psl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    psl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    psl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/positional_sequential_list_core_test.sv */
// Self-checking testbench: positional list requests checked against a predicted list.
module positional_sequential_list_core_test;
    import psl_pkg::*;

    localparam int LIST_CAP         = CAPACITY_DEF;
    localparam int PHASE_ITEMS      = 300;
    localparam int PRESSURE_ITEMS   = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 60;
    localparam int CYCLE_LIMIT      = 1000000;

    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];

    logic signed [31:0] list_store [LIST_CAP] = '{default: '0};
    int                 list_count = 0;

    int   plan_len      = 0;
    bit   plan_filling  = 1'b1;
    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    bit   hold_arm      = 1'b0;
    int   hold_left     = 0;
    int   mismatch_count = 0;
    int   cycle_count   = 0;
    t_rsp rsp_want;

    positional_sequential_list_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_rsp list_apply(t_req r);
        t_rsp rsp;
        int   k;
        int   pos;
        rsp = '0;
        pos = int'(r.position);
        case (r.req_type)
            REQ_INSERT: begin
                if (pos >= 1 && pos <= list_count + 1 && list_count < LIST_CAP) begin
                    for (k = list_count; k >= pos; k--)
                        list_store[k] = list_store[k - 1];
                    list_store[pos - 1] = r.value;
                    list_count++;
                    rsp.ok = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (pos >= 1 && pos <= list_count) begin
                    rsp.read_value = list_store[pos - 1];
                    for (k = pos; k < list_count; k++)
                        list_store[k - 1] = list_store[k];
                    list_count--;
                    rsp.ok = 1'b1;
                end
            end
            REQ_GET: begin
                if (pos >= 1 && pos <= list_count) begin
                    rsp.read_value = list_store[pos - 1];
                    rsp.ok = 1'b1;
                end
            end
            REQ_LOCATE: begin
                for (k = 0; k < list_count; k++) begin
                    if (!rsp.ok && list_store[k] == r.value) begin
                        rsp.ok = 1'b1;
                        rsp.found_position = OUT_POS_W'(k + 1);
                    end
                end
            end
            REQ_CLEAR: begin
                for (k = 0; k < LIST_CAP; k++)
                    list_store[k] = '0;
                list_count = 0;
                rsp.ok = 1'b1;
            end
            default: ;
        endcase
        rsp.list_length = OUT_POS_W'(list_count);
        return rsp;
    endfunction

    function automatic void queue_req(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
        t_req r;
        int   p;
        p = int'(pos);
        r.req_type = kind;
        r.position = pos;
        r.value    = val;
        pending_reqs.push_back(r);
        case (kind)
            REQ_INSERT: if (p >= 1 && p <= plan_len + 1 && plan_len < LIST_CAP) plan_len++;
            REQ_DELETE: if (p >= 1 && p <= plan_len) plan_len--;
            REQ_CLEAR:  plan_len = 0;
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 5) begin
            case ($urandom_range(5))
                0: return 32'sd0;
                1: return -32'sd1;
                2: return 32'sd1;
                3: return 32'sh7fff_ffff;
                4: return 32'sh8000_0000;
                default: return 32'sd12345;
            endcase
        end
        if (r < 9)
            return $urandom;
        return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    task automatic plan_random(int count);
        int         made;
        int         r;
        logic [2:0] kind;
        logic [7:0] pos;
        made = 0;
        while (made < count) begin
            if (plan_len == LIST_CAP)
                plan_filling = 1'b0;
            else if (plan_len == 0)
                plan_filling = 1'b1;
            r = $urandom_range(99);
            if (r < 2)
                kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
            else if (r < 3)
                kind = REQ_CLEAR;
            else if (r < (plan_filling ? 60 : 18))
                kind = REQ_INSERT;
            else if (r < (plan_filling ? 72 : 66))
                kind = REQ_DELETE;
            else if (r < 86)
                kind = REQ_GET;
            else
                kind = REQ_LOCATE;
            if ($urandom_range(99) < 88) begin
                if (kind == REQ_INSERT)
                    pos = 8'($urandom_range(1, plan_len + 1));
                else
                    pos = (plan_len == 0) ? 8'd1 : 8'($urandom_range(1, plan_len));
            end else begin
                case ($urandom_range(2))
                    0: pos = 8'd0;
                    1: pos = 8'(plan_len + 1 + (kind == REQ_INSERT));
                    default: pos = 8'($urandom_range(255));
                endcase
            end
            queue_req(kind, pos, pick_value());
            if (kind <= REQ_CLEAR)
                made++;
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int count);
        @(negedge i_clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        plan_random(count);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_rsps.push_back(list_apply(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_data  <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result transfer %p", o_out_data);
                    mismatch_count++;
                end else begin
                    rsp_want = expected_rsps.pop_front();
                    if (o_out_data.ok !== rsp_want.ok) begin
                        $error("ok expected %0d got %0d", rsp_want.ok, o_out_data.ok);
                        mismatch_count++;
                    end
                    if (o_out_data.read_value !== rsp_want.read_value) begin
                        $error("read_value expected %0d got %0d",
                               rsp_want.read_value, o_out_data.read_value);
                        mismatch_count++;
                    end
                    if (o_out_data.found_position !== rsp_want.found_position) begin
                        $error("found_position expected %0d got %0d",
                               rsp_want.found_position, o_out_data.found_position);
                        mismatch_count++;
                    end
                    if (o_out_data.list_length !== rsp_want.list_length) begin
                        $error("list_length expected %0d got %0d",
                               rsp_want.list_length, o_out_data.list_length);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (hold_arm)
            hold_left <= LONG_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("positional_sequential_list_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_req(REQ_GET,    8'd1,   32'sd0);
        queue_req(REQ_DELETE, 8'd0,   32'sd0);
        queue_req(REQ_LOCATE, 8'd0,   32'sd0);
        queue_req(REQ_INSERT, 8'd0,   32'sd7);
        queue_req(REQ_INSERT, 8'd2,   32'sd7);
        queue_req(REQ_INSERT, 8'd1,   32'sh7fff_ffff);
        queue_req(REQ_INSERT, 8'd2,   32'sh8000_0000);
        queue_req(REQ_INSERT, 8'd1,   -32'sd1);
        queue_req(REQ_INSERT, 8'd2,   32'sd5);
        queue_req(REQ_GET,    8'd4,   32'sd0);
        queue_req(REQ_GET,    8'd5,   32'sd0);
        queue_req(REQ_GET,    8'd255, 32'sd0);
        queue_req(REQ_LOCATE, 8'd0,   32'sh7fff_ffff);
        queue_req(REQ_INSERT, 8'd5,   32'sd5);
        queue_req(REQ_LOCATE, 8'd9,   32'sd5);
        queue_req(REQ_DELETE, 8'd2,   32'sd0);
        queue_req(REQ_LOCATE, 8'd0,   32'sd5);
        queue_req(REQ_DELETE, 8'd6,   32'sd0);
        queue_req(REQ_DELETE, 8'd4,   32'sd0);
        queue_req(REQ_LOCATE, 8'd0,   32'sd99);
        queue_req(REQ_RSVD_LO, 8'd1,  32'sd1);
        queue_req(3'd6,       8'd128, -32'sd1);
        queue_req(REQ_RSVD_HI, 8'd255, 32'sh8000_0000);
        queue_req(REQ_CLEAR,  8'd255, -32'sd1);
        queue_req(REQ_GET,    8'd1,   32'sd0);
        queue_req(REQ_INSERT, 8'd128, 32'sd3);
        drain();

        run_phase(0,  0,  PHASE_ITEMS);
        run_phase(55, 0,  PHASE_ITEMS);
        run_phase(0,  55, PHASE_ITEMS);
        run_phase(13, 13, PHASE_ITEMS);

        // hold the result side off while requests keep coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_arm     = 1'b1;
        @(negedge i_clk);
        hold_arm     = 1'b0;
        plan_random(PRESSURE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0) begin
            $display("positional_sequential_list_core verification clean");
        end else begin
            $display("positional_sequential_list_core verification failed");
        end
        $finish;
    end

endmodule

/* positional_sequential_list_core.f */
rtl/psl_pkg.sv
rtl/psl_ctrl.sv
rtl/psl_dp.sv
rtl/positional_sequential_list_core.sv
tb/positional_sequential_list_core_test.sv
